/* rtl/dsu_pkg.sv */
// shared constants, types and helpers of the disjoint-set union engine
package dsu_pkg;

   // element table geometry
   localparam int MAX_ELEMENTS = 1024;
   localparam int IDX_W        = $clog2(MAX_ELEMENTS);
   localparam int SIZE_W       = $clog2(MAX_ELEMENTS) + 1;
   localparam int COUNT_W      = 11;

   // operation codes of a request transaction
   localparam logic CMD_UNION = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // controller states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PARENT,
      ST_GRAND,
      ST_SIZE_B,
      ST_LINK,
      ST_EMIT
   } dsu_state_type;

   // datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_STEP,
      OP_HALVE,
      OP_ROOT_A,
      OP_ROOT_B,
      OP_SIZE_B,
      OP_LINK,
      OP_EMIT
   } dsu_op_type;

   // controller to datapath
   typedef struct packed {
      dsu_op_type op;
   } dsu_ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic range_err;
      logic p_is_root;
      logic same_root;
      logic is_query;
      logic clr_last;
      logic rsp_busy;
   } dsu_stat_type;

   // written count saturated into 1..MAX_ELEMENTS
   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] value);
      logic [COUNT_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = COUNT_W'(1);
      end else if (value > COUNT_W'(MAX_ELEMENTS)) begin
         result = COUNT_W'(MAX_ELEMENTS);
      end
      return result;
   endfunction

endpackage

/* rtl/dsu_req_if.sv */
// request channel: operation and two element indexes
interface dsu_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [dsu_pkg::IDX_W-1:0]  elem_a;
   logic [dsu_pkg::IDX_W-1:0]  elem_b;

   modport source (output valid, output cmd, output elem_a, output elem_b, input ready);
   modport sink (input valid, input cmd, input elem_a, input elem_b, output ready);
endinterface

/* rtl/dsu_rsp_if.sv */
// response channel: connectivity and range error flags
interface dsu_rsp_if;
   logic valid;
   logic ready;
   logic connected;
   logic range_error;

   modport source (output valid, output connected, output range_error, input ready);
   modport sink (input valid, input connected, input range_error, output ready);
endinterface

/* rtl/dsu_csr_if.sv */
// configuration write channel: element count
interface dsu_csr_if;
   logic                        valid;
   logic                        ready;
   logic [dsu_pkg::COUNT_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

/* rtl/disjoint_set_union_engine_unit.sv */
// Disjoint-set union engine: union-by-size with path halving over a
// 1024-entry parent table and size table, each a single-port-read,
// single-port-write memory with registered read data. One transaction is
// handled at a time. After reset and after every element count write the
// engine sweeps both tables back to singletons, one entry per cycle,
// during which req_if.ready stays low. A transaction whose index is at or
// beyond the count goes straight to the response state, where it waits for
// the response register. Otherwise each root walk ends by recognizing the
// root and takes per hop a parent read, then a grandparent read with the
// halving write; a query walks both roots and then answers, a union that
// links two trees then reads both root sizes and links, and a union of
// elements that already share a root ends after the second walk;
// union-by-size keeps each walk at most log2 of the count hops. A
// union answers nothing; queries and range errors answer with one response
// transaction, held in an output register until taken. The count port is
// always ready; no request is taken in the cycle of a count write.
module disjoint_set_union_engine_unit (
   input logic      clock,
   input logic      reset,
   dsu_req_if.sink  req_if,
   dsu_rsp_if.source rsp_if,
   dsu_csr_if.sink  csr_if
);

   dsu_pkg::dsu_ctrl_type ctrl;
   dsu_pkg::dsu_stat_type stat;
   logic                  csr_fire;

   // count writes are taken in every cycle
   assign csr_if.ready = 1'b1;
   assign csr_fire     = csr_if.valid;

   // sequencer
   dsu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .csr_fire  (csr_fire),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // tables and registers
   dsu_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .stat            (stat),
      .req_cmd         (req_if.cmd),
      .req_elem_a      (req_if.elem_a),
      .req_elem_b      (req_if.elem_b),
      .csr_fire        (csr_fire),
      .csr_data        (csr_if.data),
      .rsp_ready       (rsp_if.ready),
      .rsp_valid       (rsp_if.valid),
      .rsp_connected   (rsp_if.connected),
      .rsp_range_error (rsp_if.range_error)
   );

endmodule

/* rtl/dsu_datapath.sv */
// parent and size tables, walk registers and response register
module dsu_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  dsu_pkg::dsu_ctrl_type       ctrl,
   output dsu_pkg::dsu_stat_type       stat,
   input  logic                        req_cmd,
   input  logic [dsu_pkg::IDX_W-1:0]   req_elem_a,
   input  logic [dsu_pkg::IDX_W-1:0]   req_elem_b,
   input  logic                        csr_fire,
   input  logic [dsu_pkg::COUNT_W-1:0] csr_data,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output logic                        rsp_connected,
   output logic                        rsp_range_error
);

   // tables
   logic [dsu_pkg::IDX_W-1:0]  parent_mem [dsu_pkg::MAX_ELEMENTS];
   logic [dsu_pkg::SIZE_W-1:0] size_mem   [dsu_pkg::MAX_ELEMENTS];

   logic [dsu_pkg::IDX_W-1:0]  par_q_ff;
   logic [dsu_pkg::SIZE_W-1:0] size_q_ff;

   logic                        par_we;
   logic [dsu_pkg::IDX_W-1:0]   par_waddr;
   logic [dsu_pkg::IDX_W-1:0]   par_wdata;
   logic [dsu_pkg::IDX_W-1:0]   par_raddr;
   logic                        size_we;
   logic [dsu_pkg::IDX_W-1:0]   size_waddr;
   logic [dsu_pkg::SIZE_W-1:0]  size_wdata;
   logic [dsu_pkg::IDX_W-1:0]   size_raddr;

   // walk and item registers
   logic [dsu_pkg::IDX_W-1:0]   x_ff, x_in;
   logic [dsu_pkg::IDX_W-1:0]   ra_ff, ra_in;
   logic [dsu_pkg::IDX_W-1:0]   b_ff, b_in;
   logic                        cmd_ff, cmd_in;
   logic                        err_ff, err_in;
   logic                        conn_ff, conn_in;
   logic [dsu_pkg::SIZE_W-1:0]  sa_ff, sa_in;

   // control registers
   logic [dsu_pkg::IDX_W-1:0]   clr_ff, clr_in;
   logic [dsu_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_conn_ff, rsp_conn_in;
   logic                        rsp_err_ff, rsp_err_in;

   logic                        out_of_range;
   logic                        a_smaller;
   logic [dsu_pkg::SIZE_W-1:0]  size_sum;

   assign out_of_range = ({1'b0, req_elem_a} >= count_ff) || ({1'b0, req_elem_b} >= count_ff);
   assign a_smaller    = sa_ff < size_q_ff;
   assign size_sum     = sa_ff + size_q_ff;

   // operation decode
   always_comb begin
      par_we      = 1'b0;
      par_waddr   = x_ff;
      par_wdata   = par_q_ff;
      par_raddr   = x_ff;
      size_we     = 1'b0;
      size_waddr  = ra_ff;
      size_wdata  = size_sum;
      size_raddr  = ra_ff;
      x_in        = x_ff;
      ra_in       = ra_ff;
      b_in        = b_ff;
      cmd_in      = cmd_ff;
      err_in      = err_ff;
      conn_in     = conn_ff;
      sa_in       = sa_ff;
      clr_in      = clr_ff;
      rsp_conn_in = rsp_conn_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (ctrl.op)
         dsu_pkg::OP_NONE: begin
         end
         dsu_pkg::OP_CLEAR: begin
            par_we     = 1'b1;
            par_waddr  = clr_ff;
            par_wdata  = clr_ff;
            size_we    = 1'b1;
            size_waddr = clr_ff;
            size_wdata = dsu_pkg::SIZE_W'(1);
            clr_in     = clr_ff + dsu_pkg::IDX_W'(1);
         end
         dsu_pkg::OP_LOAD: begin
            par_raddr = req_elem_a;
            x_in      = req_elem_a;
            b_in      = req_elem_b;
            cmd_in    = req_cmd;
            err_in    = out_of_range;
            conn_in   = 1'b0;
         end
         dsu_pkg::OP_STEP: begin
            par_raddr = par_q_ff;
         end
         dsu_pkg::OP_HALVE: begin
            // grandparent becomes parent, walk moves to it
            par_we    = 1'b1;
            par_waddr = x_ff;
            par_wdata = par_q_ff;
            par_raddr = par_q_ff;
            x_in      = par_q_ff;
         end
         dsu_pkg::OP_ROOT_A: begin
            ra_in     = x_ff;
            x_in      = b_ff;
            par_raddr = b_ff;
         end
         dsu_pkg::OP_ROOT_B: begin
            conn_in    = (ra_ff == x_ff);
            size_raddr = ra_ff;
         end
         dsu_pkg::OP_SIZE_B: begin
            size_raddr = x_ff;
            sa_in      = size_q_ff;
         end
         dsu_pkg::OP_LINK: begin
            // smaller tree hangs under larger, tie keeps the first root
            par_we  = 1'b1;
            size_we = 1'b1;
            if (a_smaller) begin
               par_waddr  = ra_ff;
               par_wdata  = x_ff;
               size_waddr = x_ff;
            end else begin
               par_waddr  = x_ff;
               par_wdata  = ra_ff;
               size_waddr = ra_ff;
            end
         end
         dsu_pkg::OP_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_conn_in  = conn_ff && !err_ff;
            rsp_err_in   = err_ff;
         end
         default: begin
         end
      endcase
   end

   // count register
   always_comb begin
      count_in = count_ff;
      if (csr_fire) begin
         count_in = dsu_pkg::clamp_count(csr_data);
      end
   end

   // status to controller
   always_comb begin
      stat.range_err = err_ff;
      stat.p_is_root = (par_q_ff == x_ff);
      stat.same_root = (ra_ff == x_ff);
      stat.is_query  = (cmd_ff == dsu_pkg::CMD_QUERY);
      stat.clr_last  = (clr_ff == dsu_pkg::IDX_W'(dsu_pkg::MAX_ELEMENTS - 1));
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   // parent table
   always_ff @(posedge clock) begin
      if (par_we) begin
         parent_mem[par_waddr] <= par_wdata;
      end
      par_q_ff <= parent_mem[par_raddr];
   end

   // size table
   always_ff @(posedge clock) begin
      if (size_we) begin
         size_mem[size_waddr] <= size_wdata;
      end
      size_q_ff <= size_mem[size_raddr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      b_ff        <= b_in;
      cmd_ff      <= cmd_in;
      err_ff      <= err_in;
      conn_ff     <= conn_in;
      sa_ff       <= sa_in;
      rsp_conn_ff <= rsp_conn_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         count_ff     <= dsu_pkg::clamp_count(dsu_pkg::COUNT_W'(1024));
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= csr_fire ? '0 : clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_connected   = rsp_conn_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

/* rtl/dsu_controller.sv */
// sequencer for clear sweep, root walks, linking and response
module dsu_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  csr_fire,
   input  dsu_pkg::dsu_stat_type stat,
   output dsu_pkg::dsu_ctrl_type ctrl
);

   dsu_pkg::dsu_state_type state_ff, state_in;
   logic                   phase_ff, phase_in;

   // next state
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      unique case (state_ff)
         dsu_pkg::ST_CLEAR: begin
            if (stat.clr_last) begin
               state_in = dsu_pkg::ST_IDLE;
            end
         end
         dsu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = dsu_pkg::ST_PARENT;
               phase_in = 1'b0;
            end
         end
         dsu_pkg::ST_PARENT: begin
            if (stat.range_err) begin
               state_in = dsu_pkg::ST_EMIT;
            end else if (!stat.p_is_root) begin
               state_in = dsu_pkg::ST_GRAND;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else if (stat.is_query) begin
               state_in = dsu_pkg::ST_EMIT;
            end else if (stat.same_root) begin
               state_in = dsu_pkg::ST_IDLE;
            end else begin
               state_in = dsu_pkg::ST_SIZE_B;
            end
         end
         dsu_pkg::ST_GRAND:  state_in = dsu_pkg::ST_PARENT;
         dsu_pkg::ST_SIZE_B: state_in = dsu_pkg::ST_LINK;
         dsu_pkg::ST_LINK:   state_in = dsu_pkg::ST_IDLE;
         dsu_pkg::ST_EMIT: begin
            if (!stat.rsp_busy) begin
               state_in = dsu_pkg::ST_IDLE;
            end
         end
         default: state_in = dsu_pkg::ST_CLEAR;
      endcase
      // a count write restarts the clear sweep
      if (csr_fire) begin
         state_in = dsu_pkg::ST_CLEAR;
      end
   end

   // outputs
   always_comb begin
      ctrl.op   = dsu_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         dsu_pkg::ST_CLEAR: begin
            ctrl.op = dsu_pkg::OP_CLEAR;
         end
         dsu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.op = dsu_pkg::OP_LOAD;
            end
         end
         dsu_pkg::ST_PARENT: begin
            if (stat.range_err) begin
               ctrl.op = dsu_pkg::OP_NONE;
            end else if (!stat.p_is_root) begin
               ctrl.op = dsu_pkg::OP_STEP;
            end else if (!phase_ff) begin
               ctrl.op = dsu_pkg::OP_ROOT_A;
            end else begin
               ctrl.op = dsu_pkg::OP_ROOT_B;
            end
         end
         dsu_pkg::ST_GRAND:  ctrl.op = dsu_pkg::OP_HALVE;
         dsu_pkg::ST_SIZE_B: ctrl.op = dsu_pkg::OP_SIZE_B;
         dsu_pkg::ST_LINK:   ctrl.op = dsu_pkg::OP_LINK;
         dsu_pkg::ST_EMIT: begin
            if (!stat.rsp_busy) begin
               ctrl.op = dsu_pkg::OP_EMIT;
            end
         end
         default: ctrl.op = dsu_pkg::OP_NONE;
      endcase
      // no request is taken while the count is written
      if (csr_fire) begin
         ctrl.op   = dsu_pkg::OP_NONE;
         req_ready = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsu_pkg::ST_CLEAR;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule
